// ===== hdl/spq_pkg.sv =====
package spq_pkg;

	localparam int PRIO_BITS = 16;
	localparam int TAG_BITS  = 16;

	localparam logic REQ_JOIN  = 1'b0;
	localparam logic REQ_LEAVE = 1'b1;

	localparam logic [1:0] STATUS_OK    = 2'd0;
	localparam logic [1:0] STATUS_EMPTY = 2'd1;
	localparam logic [1:0] STATUS_FULL  = 2'd2;

	typedef struct packed {
		logic                 req_type;
		logic [TAG_BITS-1:0]  value_tag;
		logic [PRIO_BITS-1:0] prio_in;
	} req_t;

	typedef struct packed {
		logic [1:0]          status;
		logic [TAG_BITS-1:0] left_value;
		logic                head_valid;
		logic [TAG_BITS-1:0] head_value;
		logic [4:0]          entry_count;
	} rsp_t;

	// broadcast to every cell of the chain
	typedef struct packed {
		logic                 upd;
		logic                 is_join;
		logic [PRIO_BITS-1:0] prio;
	} cmd_t;

endpackage

// ===== hdl/spq_cell.sv =====
module spq_cell #(
	parameter int VALUE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  spq_pkg::cmd_t                 cmd,
	input  logic [VALUE_BITS-1:0]         new_val,
	input  logic                          left_keep,
	input  logic                          left_vld,
	input  logic [spq_pkg::PRIO_BITS-1:0] left_prio,
	input  logic [VALUE_BITS-1:0]         left_val,
	input  logic                          right_vld,
	input  logic [spq_pkg::PRIO_BITS-1:0] right_prio,
	input  logic [VALUE_BITS-1:0]         right_val,
	output logic                          keep,
	output logic                          vld,
	output logic [spq_pkg::PRIO_BITS-1:0] prio,
	output logic [VALUE_BITS-1:0]         val,
	output logic                          nxt_vld,
	output logic [VALUE_BITS-1:0]         nxt_val
);

	logic                          vld_q;
	logic [spq_pkg::PRIO_BITS-1:0] prio_q;
	logic [VALUE_BITS-1:0]         val_q;
	logic [spq_pkg::PRIO_BITS-1:0] nxt_prio;

	// strictly lower priority stays ahead of the new entry
	assign keep = vld_q && (prio_q < cmd.prio);

	always_comb begin
		nxt_vld  = vld_q;
		nxt_prio = prio_q;
		nxt_val  = val_q;
		if (cmd.upd) begin
			if (cmd.is_join) begin
				if (keep) begin
					nxt_vld = vld_q;
				end else if (left_keep) begin
					nxt_vld  = 1'b1;
					nxt_prio = cmd.prio;
					nxt_val  = new_val;
				end else begin
					nxt_vld  = left_vld;
					nxt_prio = left_prio;
					nxt_val  = left_val;
				end
			end else begin
				nxt_vld  = right_vld;
				nxt_prio = right_prio;
				nxt_val  = right_val;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else begin
			vld_q <= nxt_vld;
		end
	end

	always_ff @(posedge clk) begin
		prio_q <= nxt_prio;
		val_q  <= nxt_val;
	end

	assign vld  = vld_q;
	assign prio = prio_q;
	assign val  = val_q;

endmodule

// ===== hdl/sorted_priority_queue_top.sv =====
// Sorted priority queue of CAPACITY entries held in a chain of cells in
// ascending priority order, cell 0 at the head; among equal priorities the
// newest join leaves first. One transaction (join or leave) is taken every
// cycle and its response is held in the response register. Every cell compares
// its own priority with the joining one in parallel and then keeps, takes the
// new entry or shifts from a neighbor, so the cycle is set by one 16-bit
// compare and a four-way select per cell. The request side stalls only while
// a response waits and the response side stalls. A join on a full queue is
// dropped with status 2, a leave on an empty queue gives status 1.
module sorted_priority_queue_top #(
	parameter int CAPACITY   = 16,
	parameter int VALUE_BITS = 16
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          req_valid,
	output logic          req_stall,
	input  spq_pkg::req_t req,
	output logic          rsp_valid,
	input  logic          rsp_stall,
	output spq_pkg::rsp_t rsp
);

	localparam int CW = $clog2(CAPACITY + 1);

	logic                          c_keep [CAPACITY];
	logic                          c_vld  [CAPACITY];
	logic [spq_pkg::PRIO_BITS-1:0] c_prio [CAPACITY];
	logic [VALUE_BITS-1:0]         c_val  [CAPACITY];
	logic                          c_nvld [CAPACITY];
	logic [VALUE_BITS-1:0]         c_nval [CAPACITY];
	logic [CAPACITY-1:0]           vld;

	spq_pkg::cmd_t         cmd;
	logic [VALUE_BITS-1:0] new_val;
	logic                  req_acc;
	logic                  full;
	logic                  empty;
	logic [CW-1:0]         cnt_q;
	logic [CW-1:0]         cnt_nxt;
	logic                  rsp_valid_q;
	spq_pkg::rsp_t         rsp_q;

	assign full    = vld[CAPACITY-1];
	assign empty   = !vld[0];
	assign req_stall = rsp_valid_q && rsp_stall;
	assign req_acc = req_valid && !req_stall;
	assign new_val = VALUE_BITS'(req.value_tag);

	always_comb begin
		cmd.is_join = (req.req_type == spq_pkg::REQ_JOIN);
		cmd.prio    = req.prio_in;
		cmd.upd     = req_acc && (cmd.is_join ? !full : !empty);
	end

	genvar i;
	generate
		for (i = 0; i < CAPACITY; i++) begin : g_cell
			logic                          l_keep;
			logic                          l_vld;
			logic [spq_pkg::PRIO_BITS-1:0] l_prio;
			logic [VALUE_BITS-1:0]         l_val;
			logic                          r_vld;
			logic [spq_pkg::PRIO_BITS-1:0] r_prio;
			logic [VALUE_BITS-1:0]         r_val;

			if (i == 0) begin : g_first
				// head cell: the new entry lands here unless this cell stays
				assign l_keep = 1'b1;
				assign l_vld  = 1'b0;
				assign l_prio = '0;
				assign l_val  = '0;
			end else begin : g_mid
				assign l_keep = c_keep[i-1];
				assign l_vld  = c_vld[i-1];
				assign l_prio = c_prio[i-1];
				assign l_val  = c_val[i-1];
			end

			if (i == CAPACITY - 1) begin : g_last
				assign r_vld  = 1'b0;
				assign r_prio = '0;
				assign r_val  = '0;
			end else begin : g_inner
				assign r_vld  = c_vld[i+1];
				assign r_prio = c_prio[i+1];
				assign r_val  = c_val[i+1];
			end

			spq_cell #(
				.VALUE_BITS(VALUE_BITS)
			) u_cell (
				.clk       (clk),
				.arst_n    (arst_n),
				.cmd       (cmd),
				.new_val   (new_val),
				.left_keep (l_keep),
				.left_vld  (l_vld),
				.left_prio (l_prio),
				.left_val  (l_val),
				.right_vld (r_vld),
				.right_prio(r_prio),
				.right_val (r_val),
				.keep      (c_keep[i]),
				.vld       (c_vld[i]),
				.prio      (c_prio[i]),
				.val       (c_val[i]),
				.nxt_vld   (c_nvld[i]),
				.nxt_val   (c_nval[i])
			);

			assign vld[i] = c_vld[i];
		end
	endgenerate

	always_comb begin
		cnt_nxt = cnt_q;
		if (cmd.upd) begin
			if (cmd.is_join) begin
				cnt_nxt = cnt_q + CW'(1);
			end else begin
				cnt_nxt = cnt_q - CW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			cnt_q <= cnt_nxt;
			if (req_acc) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			if (cmd.is_join) begin
				rsp_q.status     <= full ? spq_pkg::STATUS_FULL : spq_pkg::STATUS_OK;
				rsp_q.left_value <= '0;
			end else begin
				rsp_q.status     <= empty ? spq_pkg::STATUS_EMPTY : spq_pkg::STATUS_OK;
				rsp_q.left_value <= empty ? '0 : spq_pkg::TAG_BITS'(c_val[0]);
			end
			rsp_q.head_valid  <= c_nvld[0];
			rsp_q.head_value  <= c_nvld[0] ? spq_pkg::TAG_BITS'(c_nval[0]) : '0;
			rsp_q.entry_count <= 5'(cnt_nxt);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

`ifndef SYNTHESIS
	a_count_matches: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(vld) == cnt_q)
		else $error("entry count differs from occupied cells");

	a_packed_front: assert property (@(posedge clk) disable iff (!arst_n)
		((vld >> 1) & ~vld) == '0)
		else $error("occupied cells not packed toward the head");

	a_head_order: assert property (@(posedge clk) disable iff (!arst_n)
		vld[1] |-> (c_prio[0] <= c_prio[1]))
		else $error("head cell out of priority order");

	a_join_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(req_acc && cmd.is_join && !full) |=> (cnt_q == CW'($past(cnt_q) + CW'(1))))
		else $error("accepted join did not add an entry");
`endif

endmodule
